/* sv/mdu_pkg.sv */
// Package with the operation codes, controller states and command struct of the HI/LO unit.
`default_nettype none
package mdu_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned OpW   = 3;
  localparam int unsigned CntW  = 5;

  localparam logic [WordW-1:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [WordW-1:0] WORD_ONE = 32'h0000_0001;
  localparam logic [CntW-1:0]  LAST_STEP = 5'd31;

  typedef enum logic [OpW-1:0] {
    OP_MULT  = 3'd0,
    OP_MULTU = 3'd1,
    OP_DIV   = 3'd2,
    OP_DIVU  = 3'd3,
    OP_MFHI  = 3'd4,
    OP_MFLO  = 3'd5,
    OP_MTHI  = 3'd6,
    OP_MTLO  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_FIX  = 3'b100
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // an input beat is taken this cycle
    logic step;    // one restoring divide iteration
    logic finish;  // write the divide result to HI/LO and the zero read value
  } cmd_t;

  function automatic logic is_div(input logic [OpW-1:0] op);
    return (op == OP_DIV) || (op == OP_DIVU);
  endfunction

endpackage
`default_nettype wire

/* sv/mdu_req_if.sv */
// Request channel: operation and two register values.
`default_nettype none
interface mdu_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] operand_a;
  logic [31:0] operand_b;

  modport source (output valid, output operation, output operand_a, output operand_b,
                  input ready);
  modport sink (input valid, input operation, input operand_a, input operand_b,
                output ready);
endinterface
`default_nettype wire

/* sv/mdu_rsp_if.sv */
// Response channel: the value read from HI or LO.
`default_nettype none
interface mdu_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_value;

  modport source (output valid, output read_value, input ready);
  modport sink (input valid, input read_value, output ready);
endinterface
`default_nettype wire

/* sv/mdu_ctrl.sv */
// Controller state machine: accepts beats, sequences the divide iterations, owns response valid.
`default_nettype none
module mdu_ctrl (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  input  wire logic [mdu_pkg::OpW-1:0]       in_op_i,
  output      logic                          in_ready_o,
  input  wire logic                          out_ready_i,
  output      logic                          out_valid_o,
  output      mdu_pkg::cmd_t                 cmd_o
);
  import mdu_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            slot_free;
  logic            accept;

  // The response register can take a new value when empty or when it drains this cycle.
  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && slot_free;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    cmd_o.accept  = accept;
    cmd_o.step    = 1'b0;
    cmd_o.finish  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept && is_div(in_op_i)) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
        if (cnt_q == LAST_STEP) begin
          state_d = ST_FIX;
        end
      end
      ST_FIX: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_ready_i;
    if ((accept && !is_div(in_op_i)) || cmd_o.finish) begin
      out_valid_d = 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule
`default_nettype wire

/* sv/mdu_datapath.sv */
// Datapath: HI/LO registers, combinational multiplier and a radix-2 restoring divider.
`default_nettype none
module mdu_datapath (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire mdu_pkg::cmd_t                 cmd_i,
  input  wire logic [mdu_pkg::OpW-1:0]       op_i,
  input  wire logic [mdu_pkg::WordW-1:0]     a_i,
  input  wire logic [mdu_pkg::WordW-1:0]     b_i,
  output      logic [mdu_pkg::WordW-1:0]     read_value_o
);
  import mdu_pkg::*;

  logic [WordW-1:0]       hi_q, lo_q;
  logic [WordW-1:0]       quot_q, rem_q, dvs_q, dvd_q;
  logic                   qneg_q, rneg_q, dzero_q;
  logic [WordW-1:0]       read_q;

  logic                   sgn_div, a_neg, b_neg;
  logic                   sgn_mul;
  logic signed [WordW:0]  mul_a, mul_b;
  logic signed [2*WordW+1:0] prod;
  logic [WordW:0]         shifted, diff;
  logic                   ge;
  logic [WordW-1:0]       quot_fix, rem_fix;

  assign sgn_div = (op_i == OP_DIV);
  assign a_neg   = sgn_div && a_i[WordW-1];
  assign b_neg   = sgn_div && b_i[WordW-1];

  assign sgn_mul = (op_i == OP_MULT);
  assign mul_a   = $signed({sgn_mul && a_i[WordW-1], a_i});
  assign mul_b   = $signed({sgn_mul && b_i[WordW-1], b_i});
  assign prod    = mul_a * mul_b;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  assign shifted = {rem_q, quot_q[WordW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = shifted >= {1'b0, dvs_q};

  assign quot_fix = qneg_q ? (~quot_q + WORD_ONE) : quot_q;
  assign rem_fix  = rneg_q ? (~rem_q + WORD_ONE) : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= '0;
      lo_q <= '0;
    end else if (cmd_i.accept) begin
      case (op_i)
        OP_MULT, OP_MULTU: begin
          hi_q <= prod[2*WordW-1:WordW];
          lo_q <= prod[WordW-1:0];
        end
        OP_MTHI: hi_q <= a_i;
        OP_MTLO: lo_q <= a_i;
        default: begin
        end
      endcase
    end else if (cmd_i.finish) begin
      if (dzero_q) begin
        // Divide by zero: HI keeps the dividend, LO is all ones, or one for a negative signed one.
        hi_q <= dvd_q;
        lo_q <= rneg_q ? WORD_ONE : ALL_ONES;
      end else begin
        hi_q <= rem_fix;
        lo_q <= quot_fix;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      quot_q  <= a_neg ? (~a_i + WORD_ONE) : a_i;
      dvs_q   <= b_neg ? (~b_i + WORD_ONE) : b_i;
      rem_q   <= '0;
      dvd_q   <= a_i;
      qneg_q  <= a_neg ^ b_neg;
      rneg_q  <= a_neg;
      dzero_q <= (b_i == '0);
    end else if (cmd_i.step) begin
      quot_q <= {quot_q[WordW-2:0], ge};
      rem_q  <= ge ? diff[WordW-1:0] : shifted[WordW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      case (op_i)
        OP_MFHI: read_q <= hi_q;
        OP_MFLO: read_q <= lo_q;
        default: read_q <= '0;
      endcase
    end else if (cmd_i.finish) begin
      read_q <= '0;
    end
  end

  assign read_value_o = read_q;

endmodule
`default_nettype wire

/* sv/mips_multiply_divide_unit.sv */
// Top level of the MIPS HI/LO multiply-divide unit.
//
//  channel  modport  direction  payload
//  req_i    sink     in         operation[2:0], operand_a[31:0], operand_b[31:0]
//  rsp_o    source   out        read_value[31:0]
//
// Multiply, move and read operations need no iterations; the product comes from one 33x33 multiplier.
// A divide has one load, 32 restoring iterations, and one sign fix and write of HI/LO.
// Reset clears HI, LO and the controller; the response register holds one beat.
// A new beat is taken while a response waits only if that response drains in the same cycle.
// A divide holds its last cycle until the response register is free.
`default_nettype none
module mips_multiply_divide_unit (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mdu_req_if.sink    req_i,
  mdu_rsp_if.source  rsp_o
);
  import mdu_pkg::*;

  cmd_t cmd;

  mdu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_op_i     (req_i.operation),
    .in_ready_o  (req_i.ready),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .cmd_o       (cmd)
  );

  mdu_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .op_i         (req_i.operation),
    .a_i          (req_i.operand_a),
    .b_i          (req_i.operand_b),
    .read_value_o (rsp_o.read_value)
  );

  // No new beat is taken while the divider iterates.
  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.step |-> !req_i.ready)
    else $error("request accepted during divide iterations");

  // A divide result never overwrites a response that has not been taken.
  a_finish_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!rsp_o.valid || rsp_o.ready))
    else $error("divide finished into a full response register");

  // A non-divide operation presents its response in the next cycle.
  a_fast_response: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.accept && !is_div(req_i.operation)) |=> rsp_o.valid)
    else $error("missing response after single-cycle operation");

endmodule
`default_nettype wire
